// File: hdl/rc_cell_model_step_defines.svh
// Assertion macros for the RC cell model step block.
`ifndef RC_CELL_MODEL_STEP_DEFINES_SVH
`define RC_CELL_MODEL_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define RCM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcm: implication check failed");
`define RCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcm: next-cycle check failed");
`else
`define RCM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/rcm_pkg.sv
package rcm_pkg;

  localparam int CUR_W   = 18;
  localparam int UP_W    = 24;
  localparam int R_W     = 17;
  localparam int CAP_W   = 20;
  localparam int OCV_W   = 23;
  localparam int NPV_W   = 24;
  localparam int TV_W    = 26;
  localparam int ALPHA_W = 17;
  localparam int TAU_W   = R_W + CAP_W;

  // step time in microseconds; the decay exponent is STEP_TIME_US / tau in Q16
  localparam longint unsigned STEP_TIME_US = 100000;
  localparam longint unsigned DIV_NUM      = STEP_TIME_US << 16;
  localparam int NUM_W = 40;          // holds DIV_NUM over the whole step range
  localparam int X_W   = 20;          // exponent below 16.0 in Q16
  localparam int CMP_W = TAU_W + X_W;

  localparam int DIV_STAGES    = X_W / 2;   // two quotient bits per stage
  localparam int TAYLOR_STAGES = 8;
  localparam int SQ_N          = 7;
  localparam int DECAY_LAT     = 2 + DIV_STAGES + TAYLOR_STAGES + SQ_N + 1;
  localparam int VOLT_STAGES   = 6;
  localparam int TOTAL_LAT     = DECAY_LAT + VOLT_STAGES;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  localparam int POLAR_LIMIT = 5000000;
  localparam int TERM_LIMIT  = 20000000;

  localparam logic [31:0] RECIP3   = 32'((64'd1 << 32) / 3);
  localparam logic [29:0] RECIP5   = 30'((64'd1 << 32) / 5);
  localparam logic [32:0] RECIP125 = 33'((64'd1 << 39) / 125);

  // largest useful polar numerator after the shift by 19 (one count above the limit)
  localparam logic [29:0] POLAR_N_MAX = 30'((POLAR_LIMIT + 1) * 125);

endpackage

// File: hdl/rcm_decay.sv
module rcm_decay import rcm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [R_W-1:0]     r1_i,
  input  logic [CAP_W-1:0]   cap_i,
  output logic               valid_o,
  output logic [ALPHA_W-1:0] alpha_o
);

  typedef enum logic [1:0] {SEL_CALC, SEL_ZERO, SEL_ONE} sel_e;
  typedef struct packed {
    logic valid;
    sel_e sel;
  } ctl_t;

  ctl_t ctl_q [DECAY_LAT];
  sel_e sel_d;

  logic [TAU_W-1:0] tau_q;
  logic [TAU_W-1:0] tau_c;

  logic [NUM_W-1:0] rem_q  [DIV_STAGES];
  logic [TAU_W-1:0] dtau_q [DIV_STAGES];
  logic [X_W-1:0]   quo_q  [DIV_STAGES+1];

  // control pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DECAY_LAT; i++) ctl_q[i] <= '0;
    end else begin
      ctl_q[0] <= '{valid: valid_i, sel: SEL_CALC};
      ctl_q[1] <= '{valid: ctl_q[0].valid, sel: sel_d};
      for (int i = 2; i < DECAY_LAT; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  // time constant, then range checks
  always_comb begin
    tau_c = (tau_q == '0) ? TAU_W'(1) : tau_q;
    if ((CMP_W'(tau_c) << X_W) <= CMP_W'(DIV_NUM)) sel_d = SEL_ZERO;
    else if (CMP_W'(tau_c) > CMP_W'(DIV_NUM))     sel_d = SEL_ONE;
    else                                           sel_d = SEL_CALC;
  end

  always_ff @(posedge clk_i) begin
    tau_q     <= r1_i * cap_i;
    rem_q[0]  <= NUM_W'(DIV_NUM);
    dtau_q[0] <= tau_c;
    quo_q[0]  <= '0;
  end

  // restoring divider, two quotient bits a stage
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [NUM_W-1:0] r_n;
    logic [X_W-1:0]   q_n;
    always_comb begin
      r_n = rem_q[s];
      q_n = quo_q[s];
      for (int j = 0; j < 2; j++) begin
        if (CMP_W'(r_n) >= (CMP_W'(dtau_q[s]) << (X_W - 1 - 2*s - j))) begin
          r_n = r_n - NUM_W'(CMP_W'(dtau_q[s]) << (X_W - 1 - 2*s - j));
          q_n[X_W - 1 - 2*s - j] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      quo_q[s+1] <= q_n;
    end
    if (s < DIV_STAGES - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        rem_q[s+1]  <= r_n;
        dtau_q[s+1] <= dtau_q[s];
      end
    end
  end

  // Taylor series of exp(-x/128), y = x/128 in Q32
  logic [28:0] y_c;
  logic [28:0] ya_q, yb_q, yc_q, yd_q, ye_q, yf_q, yg_q;
  logic [57:0] p2a_q;
  logic [24:0] t2b_q, t2c_q, t2d_q, t2e_q, t2f_q, t2g_q;
  logic [53:0] p3b_q;
  logic [21:0] n3c_q;
  logic [53:0] q3c_q;
  logic [21:0] t3_c, t3r_c, t3d_q, t3e_q, t3f_q, t3g_q;
  logic [49:0] p4e_q;
  logic [15:0] t4f_q, t4g_q;
  logic [44:0] p5f_q;
  logic [12:0] n5g_q;
  logic [42:0] q5g_q;
  logic [12:0] t5_c, t5r_c;
  logic [33:0] e_c;
  logic [32:0] sq_q [SQ_N+1];

  assign y_c = {quo_q[DIV_STAGES], 9'b0};

  always_comb begin
    t3_c  = q3c_q[53:32];
    t3r_c = n3c_q - 22'(t3_c * 22'd3);
    if (t3r_c >= 22'd3) t3_c = t3_c + 22'd1;
    t5_c  = {2'b0, q5g_q[42:32]};
    t5r_c = n5g_q - 13'(t5_c * 13'd5);
    if (t5r_c >= 13'd5) t5_c = t5_c + 13'd1;
    e_c = (34'd1 << 32) - 34'(yg_q) + 34'(t2g_q) - 34'(t3g_q) + 34'(t4g_q) - 34'(t5_c);
  end

  always_ff @(posedge clk_i) begin
    ya_q  <= y_c;
    p2a_q <= y_c * y_c;
    yb_q  <= ya_q;
    t2b_q <= p2a_q[57:33];
    p3b_q <= p2a_q[57:33] * ya_q;
    yc_q  <= yb_q;
    t2c_q <= t2b_q;
    n3c_q <= p3b_q[53:32];
    q3c_q <= p3b_q[53:32] * RECIP3;
    yd_q  <= yc_q;
    t2d_q <= t2c_q;
    t3d_q <= t3_c;
    ye_q  <= yd_q;
    t2e_q <= t2d_q;
    t3e_q <= t3d_q;
    p4e_q <= t3d_q * yd_q;
    yf_q  <= ye_q;
    t2f_q <= t2e_q;
    t3f_q <= t3e_q;
    t4f_q <= p4e_q[49:34];
    p5f_q <= p4e_q[49:34] * ye_q;
    yg_q  <= yf_q;
    t2g_q <= t2f_q;
    t3g_q <= t3f_q;
    t4g_q <= t4f_q;
    n5g_q <= p5f_q[44:32];
    q5g_q <= p5f_q[44:32] * RECIP5;
    sq_q[0] <= e_c[32:0];
  end

  // seven squarings raise the series to the 128th power
  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    logic [65:0] sq_p;
    assign sq_p = sq_q[k] * sq_q[k];
    always_ff @(posedge clk_i) begin
      sq_q[k+1] <= sq_p[64:32];
    end
  end

  logic [32:0] rnd_c;
  logic [ALPHA_W-1:0] alpha_q;

  assign rnd_c = sq_q[SQ_N] + 33'd32768;

  always_ff @(posedge clk_i) begin
    unique case (ctl_q[DECAY_LAT-2].sel)
      SEL_ZERO: alpha_q <= '0;
      SEL_ONE:  alpha_q <= ALPHA_ONE;
      default:  alpha_q <= rnd_c[32:16];
    endcase
  end

  assign valid_o = ctl_q[DECAY_LAT-1].valid;
  assign alpha_o = alpha_q;

endmodule

// File: hdl/rc_cell_model_step.sv
// done_o is high in the cycle before the edge that takes an item's result.
// Throughput: one item per cycle; busy is never raised, so start may be held high.
// The depth is set by the 10-stage divider for dt/tau, the 8-stage series and
// the seven squaring multipliers, then six stages of voltage arithmetic.
// Reset (rst_ni low, asynchronous) drops every item in flight; results carry no state.
`include "rc_cell_model_step_defines.svh"

module rc_cell_model_step import rcm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CUR_W-1:0] cell_current_i,
  input  logic signed [UP_W-1:0]  polar_volt_i,
  input  logic [R_W-1:0]          series_res_i,
  input  logic [R_W-1:0]          branch_res_i,
  input  logic [CAP_W-1:0]        branch_cap_i,
  input  logic [OCV_W-1:0]        open_volt_i,
  output logic                    done_o,
  output logic signed [NPV_W-1:0] next_polar_volt_o,
  output logic signed [TV_W-1:0]  terminal_volt_o,
  output logic [ALPHA_W-1:0]      decay_factor_o
);

  // fields the voltage stages need once alpha is known
  typedef struct packed {
    logic signed [CUR_W-1:0] cur;
    logic signed [UP_W-1:0]  up;
    logic [R_W-1:0]          r0;
    logic [R_W-1:0]          r1;
    logic [OCV_W-1:0]        ocv;
  } item_t;

  // floor(n/125) from the reciprocal product; the estimate is at most one low
  function automatic logic [25:0] div125_fix(input logic [31:0] n, input logic [64:0] prod);
    logic [25:0] q;
    logic [31:0] r;
    q = prod[64:39];
    r = n - 32'(q) * 32'd125;
    if (r >= 32'd125) q = q + 26'd1;
    return q;
  endfunction

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // decay factor pipeline
  logic               dec_valid;
  logic [ALPHA_W-1:0] dec_alpha;

  rcm_decay u_decay (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .r1_i    (branch_res_i),
    .cap_i   (branch_cap_i),
    .valid_o (dec_valid),
    .alpha_o (dec_alpha)
  );

  // item fields ride alongside the decay pipeline
  item_t dly_q [DECAY_LAT];

  always_ff @(posedge clk_i) begin
    dly_q[0] <= '{cur: cell_current_i, up: polar_volt_i, r0: series_res_i,
                  r1: branch_res_i, ocv: open_volt_i};
    for (int i = 1; i < DECAY_LAT; i++) dly_q[i] <= dly_q[i-1];
  end

  // valid bits of the voltage stages
  logic [VOLT_STAGES-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[VOLT_STAGES-2:0], dec_valid};
    end
  end

  logic [ALPHA_W-1:0] a_q [VOLT_STAGES];

  always_ff @(posedge clk_i) begin
    a_q[0] <= dec_alpha;
    for (int i = 1; i < VOLT_STAGES; i++) a_q[i] <= a_q[i-1];
  end

  // stage 1: first products
  item_t                   it;
  logic signed [41:0]      m1_q;    // alpha * u_p
  logic [33:0]             m2_q;    // (1 - alpha) * r1
  logic signed [35:0]      m3_q;    // i * r0
  logic signed [CUR_W-1:0] cur1_q;
  logic [OCV_W-1:0]        ocv1_q;

  assign it = dly_q[DECAY_LAT-1];

  always_ff @(posedge clk_i) begin
    m1_q   <= $signed({1'b0, dec_alpha}) * it.up;
    m2_q   <= (ALPHA_ONE - dec_alpha) * it.r1;
    m3_q   <= it.cur * $signed({1'b0, it.r0});
    cur1_q <= it.cur;
    ocv1_q <= it.ocv;
  end

  // stage 2: scale by 1000 and finish the current term
  logic signed [51:0] m1k_q;
  logic signed [52:0] m2c_q;
  logic signed [36:0] v_q;      // u_ocv*1000 - i*r0

  always_ff @(posedge clk_i) begin
    m1k_q <= m1_q * 52'sd1000;
    m2c_q <= $signed({1'b0, m2_q}) * cur1_q;
    v_q   <= $signed({14'b0, ocv1_q}) * 37'sd1000 - m3_q;
  end

  // stage 3: magnitudes with rounding offset; 65536000 = 2^19 * 125, 1000 = 2^3 * 125
  logic signed [53:0] num_c;
  logic [53:0]        magp_c;
  logic [34:0]        shp_c;
  logic [29:0]        np_c;
  logic [36:0]        magt_c;
  logic [29:0]        np3_q;
  logic [31:0]        nt3_q;
  logic               negp3_q, negt3_q;

  always_comb begin
    num_c  = m1k_q + m2c_q;
    magp_c = (num_c < 0) ? 54'(-num_c) : 54'(num_c);
    magp_c = magp_c + 54'd32768000;
    shp_c  = magp_c[53:19];
    np_c   = (shp_c > 35'(POLAR_N_MAX)) ? POLAR_N_MAX : shp_c[29:0];
    magt_c = (v_q < 0) ? 37'(-v_q) : 37'(v_q);
    magt_c = magt_c + 37'd500;
  end

  always_ff @(posedge clk_i) begin
    np3_q   <= np_c;
    nt3_q   <= magt_c[34:3];
    negp3_q <= num_c < 0;
    negt3_q <= v_q < 0;
  end

  // stage 4: reciprocal products
  logic [62:0] prodp4_q;
  logic [64:0] prodt4_q;
  logic [29:0] np4_q;
  logic [31:0] nt4_q;
  logic        negp4_q, negt4_q;

  always_ff @(posedge clk_i) begin
    prodp4_q <= np3_q * RECIP125;
    prodt4_q <= nt3_q * RECIP125;
    np4_q    <= np3_q;
    nt4_q    <= nt3_q;
    negp4_q  <= negp3_q;
    negt4_q  <= negt3_q;
  end

  // stage 5: correct quotients, saturate and sign the polarization voltage
  logic [25:0]              qp_c, qt_c, qps_c;
  logic signed [NPV_W-1:0]  upn5_q;
  logic signed [26:0]       qt5_q;

  always_comb begin
    qp_c  = div125_fix({2'b0, np4_q}, 65'(prodp4_q));
    qt_c  = div125_fix(nt4_q, prodt4_q);
    qps_c = (qp_c > 26'(POLAR_LIMIT)) ? 26'(POLAR_LIMIT) : qp_c;
  end

  always_ff @(posedge clk_i) begin
    upn5_q <= negp4_q ? -$signed(qps_c[NPV_W-1:0]) : $signed(qps_c[NPV_W-1:0]);
    qt5_q  <= negt4_q ? -$signed({1'b0, qt_c}) : $signed({1'b0, qt_c});
  end

  // stage 6: terminal voltage and output register
  logic signed [27:0]      ut_c;
  logic signed [TV_W-1:0]  tv_q;
  logic signed [NPV_W-1:0] npv_q;

  assign ut_c = 28'(qt5_q) - 28'(upn5_q);

  always_ff @(posedge clk_i) begin
    if (ut_c > 28'sd20000000)       tv_q <= TV_W'(TERM_LIMIT);
    else if (ut_c < -28'sd20000000) tv_q <= -TV_W'(TERM_LIMIT);
    else                            tv_q <= ut_c[TV_W-1:0];
    npv_q <= upn5_q;
  end

  assign done_o            = vld_q[VOLT_STAGES-1];
  assign next_polar_volt_o = npv_q;
  assign terminal_volt_o   = tv_q;
  assign decay_factor_o    = a_q[VOLT_STAGES-1];

  // polarization output stays inside its saturation range
  logic npv_in_range;
  assign npv_in_range = (next_polar_volt_o <= 24'sd5000000) &&
                        (next_polar_volt_o >= -24'sd5000000);

  // every result comes from an item that start and accept took in
  `RCM_ASSERT_IMPL(a_done_from_item, clk_i, rst_ni, done_o, $past(accept, TOTAL_LAT))
  `RCM_ASSERT_IMPL(a_polar_sat, clk_i, rst_ni, done_o, npv_in_range)
  `RCM_ASSERT_IMPL(a_decay_range, clk_i, rst_ni, done_o, decay_factor_o <= ALPHA_ONE)
  `RCM_ASSERT_NEXT(a_decay_to_volt, clk_i, rst_ni, dec_valid, vld_q[0])

endmodule
